[src/tacs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacs_pkg
// Shared types and constants of the tile animation copy scheduler.
// ----------------------------------------------------------------------------
package tacs_pkg;

    // Width of the shared divider operands
    localparam int DIV_W = 16;

    // Input selector codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_COPY   = 2'd0;
    localparam logic [1:0] KIND_PERIOD = 2'd1;
    localparam logic [1:0] KIND_NOCOPY = 2'd2;

    // Configuration register indexes
    localparam logic [3:0] CFG_ENTRY_COUNT  = 4'd0;
    localparam logic [3:0] CFG_ANIM_DISABLE = 4'd1;

    localparam logic [15:0] FALLBACK_PERIOD = 16'(640 * 9);
    localparam logic [31:0] PERIOD_LIMIT    = 32'h0000_FFFF;
    localparam logic [31:0] VRAM_BASE       = 32'h0600_0000;

    // Entry layout in the descriptor memory
    localparam int ENTRY_W = 70;

    typedef struct packed {
        logic [31:0] gfx_base;
        logic [10:0] first_tile;
        logic [10:0] tiles_per_frame;
        logic [7:0]  frame_count;
        logic [7:0]  frame_speed;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

[src/tacs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tacs_ram #(
    parameter int WIDTH = 70,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/tacs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacs_div
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module tacs_div
    import tacs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            q_next    = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CW'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract where it fits
            if (fits) begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            q_next   = {q_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = rem_reg;

endmodule

[src/tile_animation_copy_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_animation_copy_scheduler
// Descriptor table for tile animations; answers period queries and turns
// clock ticks into copy requests, walking entries with one shared divider.
// ----------------------------------------------------------------------------
//
//  channel | ports              | item
//  --------+--------------------+-------------------------------------------
//  input   | s_tvalid/s_tready  | load, period query or tick (s_tuser = func)
//  result  | m_tvalid/m_tready  | copy request, period answer or no-copy
//  config  | cfg_valid/ready    | entry_count (0), anim_disable (1)
//
//  Ticks and queries walk the active entries through one shared 16-bit
//  divider. A firing tick entry takes two divisions; a query entry takes
//  one division per Euclid step and one for the LCM.
//  Reset clears the sequencer, the result valid flag and the config registers;
//  the descriptor memory holds nothing meaningful until loaded. A stalled
//  result channel holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module tile_animation_copy_scheduler
    import tacs_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] entry_index, [11:4] frame_speed, [19:12] frame_count,
    // [30:20] tiles_per_frame, [41:31] first_tile, [73:42] gfx_base,
    // [89:74] clock_value, [95:90] zero
    input  logic [95:0]  s_tdata,
    // [1:0] func
    input  logic [1:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] source_addr, [63:32] dest_addr, [79:64] copy_bytes,
    // [95:80] period, [96] period_fallback, [103:97] zero
    output logic [103:0] m_tdata,
    // [1:0] kind
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [4:0]   cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_CAP   = 4'd2;
    localparam logic [3:0] S_QCHK  = 4'd3;
    localparam logic [3:0] S_GCD   = 4'd4;
    localparam logic [3:0] S_GMOD  = 4'd5;
    localparam logic [3:0] S_LDIV  = 4'd6;
    localparam logic [3:0] S_LCHK  = 4'd7;
    localparam logic [3:0] S_QEMIT = 4'd8;
    localparam logic [3:0] S_TCHK  = 4'd9;
    localparam logic [3:0] S_TDIV1 = 4'd10;
    localparam logic [3:0] S_TDIV2 = 4'd11;
    localparam logic [3:0] S_TCOPY = 4'd12;
    localparam logic [3:0] S_TFIN  = 4'd13;
    localparam logic [3:0] S_NEXT  = 4'd14;

    // input field split
    logic [1:0]  in_func;
    logic [3:0]  in_entry_index;
    logic [15:0] in_clock_value;
    entry_t      in_entry;

    assign in_func                  = s_tuser;
    assign in_entry_index           = s_tdata[3:0];
    assign in_entry.frame_speed     = s_tdata[11:4];
    assign in_entry.frame_count     = s_tdata[19:12];
    assign in_entry.tiles_per_frame = s_tdata[30:20];
    assign in_entry.first_tile      = s_tdata[41:31];
    assign in_entry.gfx_base        = s_tdata[73:42];
    assign in_clock_value           = s_tdata[89:74];

    // config registers
    logic [4:0] entry_count_reg;
    logic       anim_disable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg  <= '0;
            anim_disable_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ENTRY_COUNT) begin
                entry_count_reg <= cfg_data;
            end else if (cfg_index == CFG_ANIM_DISABLE) begin
                anim_disable_reg <= cfg_data[0];
            end
        end
    end

    // clamp the active count to the table depth
    logic [CW-1:0] n_active;
    assign n_active = (32'(entry_count_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                           : CW'(entry_count_reg);

    // sequencer registers
    logic [3:0]    state_reg, state_next;
    logic          mode_tick_reg, mode_tick_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [15:0]   clk_reg, clk_next;
    logic [15:0]   lcm_reg, lcm_next;
    logic [31:0]   lcm_wide_reg, lcm_wide_next;
    logic          fb_reg, fb_next;
    logic [15:0]   prod_reg, prod_next;
    logic [15:0]   ga_reg, ga_next;
    logic [15:0]   gb_reg, gb_next;
    logic [18:0]   mult_reg, mult_next;
    entry_t        ent_reg, ent_next;

    // one held copy request, so the final one can carry last
    logic          pend_valid_reg, pend_valid_next;
    logic [31:0]   pend_src_reg, pend_src_next;
    logic [31:0]   pend_dst_reg, pend_dst_next;
    logic [15:0]   pend_bytes_reg, pend_bytes_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic [31:0]   out_src_reg, out_src_next;
    logic [31:0]   out_dst_reg, out_dst_next;
    logic [15:0]   out_bytes_reg, out_bytes_next;
    logic [15:0]   out_period_reg, out_period_next;
    logic          out_fb_reg, out_fb_next;
    logic          out_last_reg, out_last_next;

    logic          in_fire;
    logic          out_free;
    logic          emit_req;
    logic          out_load;
    logic          ram_we;
    entry_t        ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic [31:0]   copy_src;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = emit_req && out_free;
    assign ram_we   = in_fire && (in_func == FUNC_LOAD)
                      && (32'(in_entry_index) < MAX_ENTRIES);
    assign ram_rdata = entry_t'(ram_rdata_raw);
    assign copy_src  = ent_reg.gfx_base + 32'({mult_reg, 5'b0});

    tacs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_entry_index)),
        .wdata (ENTRY_W'(in_entry)),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata_raw)
    );

    tacs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next      = state_reg;
        mode_tick_next  = mode_tick_reg;
        idx_next        = idx_reg;
        clk_next        = clk_reg;
        lcm_next        = lcm_reg;
        lcm_wide_next   = lcm_wide_reg;
        fb_next         = fb_reg;
        prod_next       = prod_reg;
        ga_next         = ga_reg;
        gb_next         = gb_reg;
        mult_next       = mult_reg;
        ent_next        = ent_reg;
        pend_valid_next = pend_valid_reg;
        pend_src_next   = pend_src_reg;
        pend_dst_next   = pend_dst_reg;
        pend_bytes_next = pend_bytes_reg;
        div_req         = '0;
        emit_req        = 1'b0;
        out_kind_next   = KIND_NOCOPY;
        out_src_next    = '0;
        out_dst_next    = '0;
        out_bytes_next  = '0;
        out_period_next = '0;
        out_fb_next     = 1'b0;
        out_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire && in_func == FUNC_QUERY) begin
                    mode_tick_next = 1'b0;
                    idx_next       = '0;
                    lcm_next       = '0;
                    fb_next        = 1'b0;
                    state_next     = (n_active == '0) ? S_QEMIT : S_READ;
                end else if (in_fire && in_func == FUNC_TICK) begin
                    mode_tick_next  = 1'b1;
                    idx_next        = '0;
                    clk_next        = in_clock_value;
                    pend_valid_next = 1'b0;
                    state_next = (anim_disable_reg || n_active == '0) ? S_TFIN : S_READ;
                end
            end
            S_READ: begin
                state_next = S_CAP;
            end
            S_CAP: begin
                ent_next   = ram_rdata;
                prod_next  = 16'(ram_rdata.frame_speed) * 16'(ram_rdata.frame_count);
                state_next = mode_tick_reg ? S_TCHK : S_QCHK;
            end
            // period query: fold this entry's product into the running LCM
            S_QCHK: begin
                if (prod_reg == '0) begin
                    state_next = S_NEXT;
                end else if (lcm_reg == '0) begin
                    lcm_next   = prod_reg;
                    state_next = S_NEXT;
                end else begin
                    ga_next    = lcm_reg;
                    gb_next    = prod_reg;
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                div_req.start = 1'b1;
                if (gb_reg == '0) begin
                    div_req.dividend = lcm_reg;
                    div_req.divisor  = ga_reg;
                    state_next       = S_LDIV;
                end else begin
                    div_req.dividend = ga_reg;
                    div_req.divisor  = gb_reg;
                    state_next       = S_GMOD;
                end
            end
            S_GMOD: begin
                if (div_rsp.done) begin
                    ga_next    = gb_reg;
                    gb_next    = div_rsp.remainder;
                    state_next = S_GCD;
                end
            end
            S_LDIV: begin
                if (div_rsp.done) begin
                    lcm_wide_next = 32'(div_rsp.quotient) * 32'(prod_reg);
                    state_next    = S_LCHK;
                end
            end
            S_LCHK: begin
                if (lcm_wide_reg > PERIOD_LIMIT) begin
                    fb_next    = 1'b1;
                    state_next = S_QEMIT;
                end else begin
                    lcm_next   = lcm_wide_reg[15:0];
                    state_next = S_NEXT;
                end
            end
            S_QEMIT: begin
                emit_req      = 1'b1;
                out_kind_next = KIND_PERIOD;
                if (fb_reg || lcm_reg == '0) begin
                    out_period_next = FALLBACK_PERIOD;
                    out_fb_next     = 1'b1;
                end else begin
                    out_period_next = lcm_reg;
                end
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            // tick: test divisibility, then derive the frame number
            S_TCHK: begin
                if (ent_reg.frame_speed == '0 || ent_reg.frame_count == '0) begin
                    state_next = S_NEXT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = clk_reg;
                    div_req.divisor  = 16'(ent_reg.frame_speed);
                    state_next       = S_TDIV1;
                end
            end
            S_TDIV1: begin
                if (div_rsp.done) begin
                    if (div_rsp.remainder != '0) begin
                        state_next = S_NEXT;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = 16'(ent_reg.frame_count);
                        state_next       = S_TDIV2;
                    end
                end
            end
            S_TDIV2: begin
                if (div_rsp.done) begin
                    mult_next  = 19'(ent_reg.tiles_per_frame) * 19'(div_rsp.remainder[7:0]);
                    state_next = S_TCOPY;
                end
            end
            S_TCOPY: begin
                // push out the held request before replacing it
                emit_req       = pend_valid_reg;
                out_kind_next  = KIND_COPY;
                out_src_next   = pend_src_reg;
                out_dst_next   = pend_dst_reg;
                out_bytes_next = pend_bytes_reg;
                out_last_next  = 1'b0;
                if (!pend_valid_reg || out_load) begin
                    pend_valid_next = 1'b1;
                    pend_src_next   = copy_src;
                    pend_dst_next   = VRAM_BASE + 32'({ent_reg.first_tile, 5'b0});
                    pend_bytes_next = {ent_reg.tiles_per_frame, 5'b0};
                    state_next      = S_NEXT;
                end
            end
            S_TFIN: begin
                emit_req = 1'b1;
                if (pend_valid_reg) begin
                    out_kind_next  = KIND_COPY;
                    out_src_next   = pend_src_reg;
                    out_dst_next   = pend_dst_reg;
                    out_bytes_next = pend_bytes_reg;
                end
                if (out_load) begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_NEXT: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == n_active) begin
                    state_next = mode_tick_reg ? S_TFIN : S_QEMIT;
                end else begin
                    state_next = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mode_tick_reg  <= 1'b0;
            idx_reg        <= '0;
            fb_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_tick_reg  <= mode_tick_next;
            idx_reg        <= idx_next;
            fb_reg         <= fb_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        clk_reg        <= clk_next;
        lcm_reg        <= lcm_next;
        lcm_wide_reg   <= lcm_wide_next;
        prod_reg       <= prod_next;
        ga_reg         <= ga_next;
        gb_reg         <= gb_next;
        mult_reg       <= mult_next;
        ent_reg        <= ent_next;
        pend_src_reg   <= pend_src_next;
        pend_dst_reg   <= pend_dst_next;
        pend_bytes_reg <= pend_bytes_next;
        if (out_load) begin
            out_kind_reg   <= out_kind_next;
            out_src_reg    <= out_src_next;
            out_dst_reg    <= out_dst_next;
            out_bytes_reg  <= out_bytes_next;
            out_period_reg <= out_period_next;
            out_fb_reg     <= out_fb_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_fb_reg, out_period_reg, out_bytes_reg,
                       out_dst_reg, out_src_reg};

    // the divider only finishes while the sequencer waits on it
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_GMOD || state_reg == S_LDIV
                          || state_reg == S_TDIV1 || state_reg == S_TDIV2))
        else $error("divider done outside a wait state");

    // period answers and no-copy results always close their item
    a_single_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_PERIOD || m_tuser == KIND_NOCOPY)) |-> m_tlast)
        else $error("single result without last");

    // the fallback flag belongs to period answers only
    a_fallback_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[96]) |-> (m_tuser == KIND_PERIOD))
        else $error("fallback flag on a non-period result");

    // a held copy request exists only during a tick walk
    a_pend_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (mode_tick_reg && state_reg != S_IDLE))
        else $error("held copy request outside a tick");

endmodule

[tb/tile_animation_copy_scheduler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_animation_copy_scheduler_tb
// Self-checking bench for the tile animation copy scheduler. A directed list
// loads corner-case descriptors and exercises empty tables, period overflow,
// disabled and silent ticks and the unused selector; random phases then mix
// loads, period queries and ticks under several register settings and random
// back-pressure on both streams. Every result item is compared field by field
// against an in-bench model of the descriptor table or a hand-written expectation.
// ----------------------------------------------------------------------------
module tile_animation_copy_scheduler_tb;
    import tacs_pkg::*;

    localparam int          MAX_ENTRIES   = 16;
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    localparam logic [31:0] TILE_BYTES    = 32'd32;
    // Quiet cycles tolerated before the run is declared hung. A full query
    // over sixteen entries with long Euclid chains stays well below this.
    localparam int          STALL_LIMIT   = 50000;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          TAIL_CYCLES   = 64;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  entry_index;
        logic [7:0]  frame_speed;
        logic [7:0]  frame_count;
        logic [10:0] tiles_per_frame;
        logic [10:0] first_tile;
        logic [31:0] gfx_base;
        logic [15:0] clock_value;
    } anim_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] copy_bytes;
        logic [15:0] period;
        logic        fallback;
        logic        last;
    } copy_result_t;

    typedef enum logic [0:0] {
        OP_ITEM,
        OP_REG
    } row_op_e;

    // One row of the directed list: either a register write or an item,
    // optionally with a hand-written expectation (single result, last set).
    typedef struct packed {
        row_op_e     op;
        logic [3:0]  reg_idx;
        logic [4:0]  reg_val;
        anim_item_t  item;
        logic        typed;
        logic [1:0]  kind;
        logic [15:0] period;
        logic        fallback;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // DUT signals; the bench-driven ones hold known values from time zero
    // ------------------------------------------------------------------------
    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [4:0]   cfg_data  = '0;

    // ------------------------------------------------------------------------
    // Model state: descriptor table and register copies
    // ------------------------------------------------------------------------
    logic [7:0]   desc_speed [MAX_ENTRIES];
    logic [7:0]   desc_count [MAX_ENTRIES];
    logic [10:0]  desc_tiles [MAX_ENTRIES];
    logic [10:0]  desc_first [MAX_ENTRIES];
    logic [31:0]  desc_base  [MAX_ENTRIES];
    logic [4:0]   entry_limit = '0;
    logic         anim_off    = 1'b0;

    copy_result_t awaited_results[$];
    dir_row_t     dir_table[$];
    int           mismatches    = 0;
    int           quiet_cycles  = 0;
    int           send_gap_max  = 0;
    int           recv_gap_max  = 0;
    bit           hold_req      = 1'b0;

    tile_animation_copy_scheduler #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scheduler model: apply one accepted item to the table copy and queue
    // the result items it must produce, in order.
    // ------------------------------------------------------------------------
    function automatic void schedule_copies(anim_item_t it);
        copy_result_t    fired[$];
        copy_result_t    r;
        int unsigned     active;
        longint unsigned common;
        longint unsigned prod;
        longint unsigned a;
        longint unsigned b;
        longint unsigned t;
        logic            overflow;
        logic [31:0]     frame;
        active = (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : entry_limit;
        case (it.func)
            FUNC_LOAD: begin
                desc_speed[it.entry_index] = it.frame_speed;
                desc_count[it.entry_index] = it.frame_count;
                desc_tiles[it.entry_index] = it.tiles_per_frame;
                desc_first[it.entry_index] = it.first_tile;
                desc_base[it.entry_index]  = it.gfx_base;
            end
            FUNC_QUERY: begin
                common   = 0;
                overflow = 1'b0;
                for (int i = 0; i < active; i++) begin
                    prod = 64'(desc_speed[i]) * 64'(desc_count[i]);
                    // skip entries that never fire
                    if (prod == 0) continue;
                    if (common == 0) begin
                        common = prod;
                    end else begin
                        a = common;
                        b = prod;
                        while (b != 0) begin
                            t = a % b;
                            a = b;
                            b = t;
                        end
                        common = (common / a) * prod;
                    end
                    // stop as soon as the running LCM leaves 16 bits
                    if (common > PERIOD_LIMIT) begin
                        overflow = 1'b1;
                        break;
                    end
                end
                if (common == 0) overflow = 1'b1;
                r          = '0;
                r.kind     = KIND_PERIOD;
                r.period   = overflow ? FALLBACK_PERIOD : common[15:0];
                r.fallback = overflow;
                r.last     = 1'b1;
                awaited_results.push_back(r);
            end
            FUNC_TICK: begin
                if (!anim_off) begin
                    for (int i = 0; i < active; i++) begin
                        if (desc_speed[i] == 0 || desc_count[i] == 0) continue;
                        if (it.clock_value % desc_speed[i] != 0) continue;
                        frame = 32'((it.clock_value / desc_speed[i]) % desc_count[i]);
                        r             = '0;
                        r.kind        = KIND_COPY;
                        r.source_addr = desc_base[i] + TILE_BYTES * 32'(desc_tiles[i]) * frame;
                        r.dest_addr   = VRAM_BASE + TILE_BYTES * 32'(desc_first[i]);
                        r.copy_bytes  = 16'(TILE_BYTES * 32'(desc_tiles[i]));
                        fired.push_back(r);
                    end
                end
                // disabled or silent tick: one no-copy item
                if (fired.size() == 0) begin
                    r      = '0;
                    r.kind = KIND_NOCOPY;
                    r.last = 1'b1;
                    fired.push_back(r);
                end else begin
                    fired[fired.size() - 1].last = 1'b1;
                end
                foreach (fired[k]) awaited_results.push_back(fired[k]);
            end
            default: begin
                // unused selector: dropped without a result
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------------
    function automatic anim_item_t mk_item(logic [1:0] func, logic [3:0] idx,
                                           logic [7:0] speed, logic [7:0] cnt,
                                           logic [10:0] tiles, logic [10:0] first,
                                           logic [31:0] base, logic [15:0] clock);
        anim_item_t it;
        it.func            = func;
        it.entry_index     = idx;
        it.frame_speed     = speed;
        it.frame_count     = cnt;
        it.tiles_per_frame = tiles;
        it.first_tile      = first;
        it.gfx_base        = base;
        it.clock_value     = clock;
        return it;
    endfunction

    function automatic dir_row_t item_row(anim_item_t it);
        dir_row_t row;
        row      = '0;
        row.op   = OP_ITEM;
        row.item = it;
        return row;
    endfunction

    function automatic dir_row_t typed_row(anim_item_t it, logic [1:0] kind,
                                           logic [15:0] period, logic fallback);
        dir_row_t row;
        row          = item_row(it);
        row.typed    = 1'b1;
        row.kind     = kind;
        row.period   = period;
        row.fallback = fallback;
        return row;
    endfunction

    function automatic dir_row_t reg_row(logic [3:0] idx, logic [4:0] val);
        dir_row_t row;
        row         = '0;
        row.op      = OP_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Load with descriptor timing biased toward small speeds and frame counts,
    // so that ticks fire often and queries settle without overflow; keep a
    // share of zeros and of full-range values.
    function automatic anim_item_t random_load(logic [3:0] idx);
        anim_item_t it;
        int unsigned pick;
        it.func        = FUNC_LOAD;
        it.entry_index = idx;
        pick = $urandom_range(0, 9);
        it.frame_speed = (pick == 0) ? 8'd0 :
                         (pick < 3)  ? 8'($urandom_range(0, 255)) :
                                       8'($urandom_range(1, 6));
        pick = $urandom_range(0, 9);
        it.frame_count = (pick == 0) ? 8'd0 :
                         (pick < 4)  ? 8'($urandom_range(0, 255)) :
                                       8'($urandom_range(1, 8));
        it.tiles_per_frame = 11'($urandom_range(1, 2047));
        it.first_tile      = 11'($urandom_range(0, 2047));
        it.gfx_base        = $urandom;
        it.clock_value     = 16'($urandom);
        return it;
    endfunction

    // Random item of any kind. Half the clocks are multiples of 12 so that
    // most small speeds divide them.
    function automatic anim_item_t random_item();
        anim_item_t it;
        int unsigned pick;
        it   = random_load(4'($urandom_range(0, 15)));
        pick = $urandom_range(0, 99);
        it.func = (pick < 35) ? FUNC_LOAD :
                  (pick < 55) ? FUNC_QUERY :
                  (pick < 95) ? FUNC_TICK : FUNC_UNUSED;
        if ($urandom_range(0, 1) == 0) begin
            it.clock_value = 16'(12 * $urandom_range(0, 5461));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input stream driver
    // ------------------------------------------------------------------------
    // Offer one item, hold it until accepted, then record its expectation:
    // either the hand-written one or whatever the model predicts.
    task automatic send_item(anim_item_t it, bit typed, copy_result_t quoted);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {6'd0, it.clock_value, it.gfx_base, it.first_tile,
                     it.tiles_per_frame, it.frame_count, it.frame_speed,
                     it.entry_index};
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            awaited_results.push_back(quoted);
        end else begin
            schedule_copies(it);
        end
        // idle between items; with no gap keep tvalid high for the next one
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop tvalid, wait for every awaited result, then let the sequencer
    // settle (a trailing load or unused item gives nothing to wait for).
    task automatic await_idle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(logic [3:0] idx, logic [4:0] val);
        await_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ENTRY_COUNT) begin
            entry_limit = val;
        end else if (idx == CFG_ANIM_DISABLE) begin
            anim_off = val[0];
        end
    endtask

    // One random phase under a given register setting and idling profile.
    task automatic run_phase(logic [4:0] count, logic disable_bit, int send_max,
                             int recv_max, int n_items, bit pressure);
        write_reg(CFG_ENTRY_COUNT, count);
        write_reg(CFG_ANIM_DISABLE, {4'd0, disable_bit});
        send_gap_max = send_max;
        recv_gap_max = recv_max;
        // the sink starts its long hold-off at its next result
        if (pressure) hold_req = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            send_item(random_item(), 1'b0, '0);
            // now and then hold the input until everything has drained
            if ($urandom_range(0, 39) == 0) await_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result stream sink: random stalls per item, plus one long hold-off on
    // request so that the scheduler backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = $urandom_range(0, recv_gap_max);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result item with the oldest awaited one.
    always @(posedge aclk) begin
        copy_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result item: kind %0d, tdata 0x%0h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("kind",            32'(want.kind),        32'(m_tuser));
                check_field("source_addr",     want.source_addr,      m_tdata[31:0]);
                check_field("dest_addr",       want.dest_addr,        m_tdata[63:32]);
                check_field("copy_bytes",      32'(want.copy_bytes),  32'(m_tdata[79:64]));
                check_field("period",          32'(want.period),      32'(m_tdata[95:80]));
                check_field("period_fallback", 32'(want.fallback),    32'(m_tdata[96]));
                check_field("last",            32'(want.last),        32'(m_tlast));
            end
        end
    end

    // Watchdog: end the run if no channel moves an item for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles, %0d results awaited",
                   STALL_LIMIT, awaited_results.size());
            $display("** tile_animation_copy_scheduler: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        copy_result_t quoted;

        // Directed list. Hand-written expectations only where they are plain:
        // empty-table fallback, the LCM of 1 and 255*255, overflow fallback and the
        // no-copy answers; everything else goes through the model.
        // Empty table: query falls back, tick is silent, unused selector drops.
        dir_table.push_back(typed_row(mk_item(FUNC_QUERY, 4'hF, 8'hFF, 8'hFF, 11'h7FF,
            11'h7FF, 32'hFFFF_FFFF, 16'hFFFF), KIND_PERIOD, FALLBACK_PERIOD, 1'b1));
        dir_table.push_back(typed_row(mk_item(FUNC_TICK, 4'h0, 8'h00, 8'h00, 11'd1,
            11'd0, 32'h0, 16'h0000), KIND_NOCOPY, 16'd0, 1'b0));
        dir_table.push_back(item_row(mk_item(FUNC_UNUSED, 4'h0, 8'h01, 8'h01, 11'd1,
            11'd0, 32'h0, 16'h0000)));
        // Extreme descriptors, a zero-speed entry and a zero-count entry.
        dir_table.push_back(item_row(mk_item(FUNC_LOAD, 4'd0, 8'd1, 8'd1, 11'd2047,
            11'd2047, 32'hFFFF_FFFF, 16'h0)));
        dir_table.push_back(item_row(mk_item(FUNC_LOAD, 4'd1, 8'd255, 8'd255, 11'd1,
            11'd0, 32'h0000_0000, 16'h0)));
        dir_table.push_back(item_row(mk_item(FUNC_LOAD, 4'd2, 8'd0, 8'd5, 11'd4,
            11'd100, 32'h0000_1000, 16'h0)));
        dir_table.push_back(item_row(mk_item(FUNC_LOAD, 4'd3, 8'd3, 8'd0, 11'd8,
            11'd5, 32'h8000_0000, 16'h0)));
        dir_table.push_back(reg_row(CFG_ENTRY_COUNT, 5'd4));
        // Clock extremes: both live entries fire.
        dir_table.push_back(item_row(mk_item(FUNC_TICK, 4'h0, 8'h0, 8'h0, 11'd1,
            11'd0, 32'h0, 16'h0000)));
        dir_table.push_back(item_row(mk_item(FUNC_TICK, 4'hF, 8'hFF, 8'hFF, 11'h7FF,
            11'h7FF, 32'hFFFF_FFFF, 16'hFFFF)));
        // LCM of 1 and 255*255 is the largest product itself.
        dir_table.push_back(typed_row(mk_item(FUNC_QUERY, 4'h0, 8'h0, 8'h0, 11'd1,
            11'd0, 32'h0, 16'h0), KIND_PERIOD, 16'd65025, 1'b0));
        // Add 2*255: LCM 130050 passes 16 bits.
        dir_table.push_back(item_row(mk_item(FUNC_LOAD, 4'd4, 8'd2, 8'd255, 11'h400,
            11'h400, 32'h5555_AAAA, 16'h0)));
        dir_table.push_back(reg_row(CFG_ENTRY_COUNT, 5'd5));
        dir_table.push_back(typed_row(mk_item(FUNC_QUERY, 4'h0, 8'h0, 8'h0, 11'd1,
            11'd0, 32'h0, 16'h0), KIND_PERIOD, FALLBACK_PERIOD, 1'b1));
        dir_table.push_back(item_row(mk_item(FUNC_TICK, 4'h0, 8'h0, 8'h0, 11'd1,
            11'd0, 32'h0, 16'h0001)));
        // Disabled: tick gives one no-copy item, query is unaffected.
        dir_table.push_back(reg_row(CFG_ANIM_DISABLE, 5'd1));
        dir_table.push_back(typed_row(mk_item(FUNC_TICK, 4'h0, 8'h0, 8'h0, 11'd1,
            11'd0, 32'h0, 16'h0000), KIND_NOCOPY, 16'd0, 1'b0));
        dir_table.push_back(item_row(mk_item(FUNC_QUERY, 4'h0, 8'h0, 8'h0, 11'd1,
            11'd0, 32'h0, 16'h0)));
        dir_table.push_back(reg_row(CFG_ANIM_DISABLE, 5'd0));
        dir_table.push_back(item_row(mk_item(FUNC_UNUSED, 4'hF, 8'hFF, 8'hFF, 11'h7FF,
            11'h7FF, 32'hFFFF_FFFF, 16'hFFFF)));

        // Hold reset low, then release it for good.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_max = 2;
        recv_gap_max = 2;
        foreach (dir_table[n]) begin
            if (dir_table[n].op == OP_REG) begin
                write_reg(dir_table[n].reg_idx, dir_table[n].reg_val);
            end else begin
                quoted          = '0;
                quoted.kind     = dir_table[n].kind;
                quoted.period   = dir_table[n].period;
                quoted.fallback = dir_table[n].fallback;
                quoted.last     = 1'b1;
                send_item(dir_table[n].item, dir_table[n].typed, quoted);
            end
        end

        // Load every remaining entry so that any count may be set afterwards.
        for (int i = 5; i < MAX_ENTRIES; i++) begin
            send_item(random_load(4'(i)), 1'b0, '0);
        end

        // Random phases: full table, oversized count with no idling, partial
        // table, empty table, disabled ticks, and one long sink hold-off.
        run_phase(5'd16, 1'b0, 4, 4, 48, 1'b0);
        run_phase(5'd31, 1'b0, 0, 0, 48, 1'b0);
        run_phase(5'($urandom_range(1, 15)), 1'b0, 4, 0, 48, 1'b0);
        run_phase(5'd0, 1'b0, 0, 4, 48, 1'b0);
        run_phase(5'd16, 1'b1, 4, 4, 48, 1'b0);
        run_phase(5'd16, 1'b0, 0, 3, 48, 1'b1);

        // Drain, then watch a while longer for stray result items.
        await_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $error("%0d result items never arrived", awaited_results.size());
        end
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("** tile_animation_copy_scheduler: PASSED **");
        end else begin
            $display("** tile_animation_copy_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
